// ----- design/jsds_pkg.sv -----
// ----------------------------------------------------------------------------
// jsds_pkg: shared types and codes for the JPEG SOF0 dimension sniffer
// Beat types for the byte and result channels, status codes and the
// expected bytes of the SOI / APP0 / JFIF file header.
// ----------------------------------------------------------------------------
package jsds_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } byte_beat_t;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  status;
  } result_beat_t;

  localparam logic [2:0] STATUS_FOUND    = 3'd0;
  localparam logic [2:0] STATUS_BAD_SOI  = 3'd1;
  localparam logic [2:0] STATUS_NOT_JFIF = 3'd2;
  localparam logic [2:0] STATUS_NO_FF    = 3'd3;
  localparam logic [2:0] STATUS_EARLY    = 3'd4;
  localparam logic [2:0] STATUS_BAD_LEN  = 3'd5;

  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] MARKER_SOF0   = 8'hC0;

  // Header offsets of note
  localparam logic [3:0] HDR_LEN_HIGH = 4'd4;
  localparam logic [3:0] HDR_LEN_LOW  = 4'd5;
  localparam logic [3:0] HDR_TAG_LAST = 4'd10;

  localparam logic [15:0] APP0_MIN_LEN = 16'd7;
  localparam logic [15:0] SEG_MIN_LEN  = 16'd2;

  // Expected header byte: FF D8 FF E0, length, "JFIF\0"
  function automatic logic [7:0] head_expect(input logic [3:0] offset);
    logic [7:0] value;
    value = 8'h00;
    case (offset)
      4'd0: value = 8'hFF;
      4'd1: value = 8'hD8;
      4'd2: value = 8'hFF;
      4'd3: value = 8'hE0;
      4'd6: value = 8'h4A;
      4'd7: value = 8'h46;
      4'd8: value = 8'h49;
      4'd9: value = 8'h46;
      default: value = 8'h00;
    endcase
    return value;
  endfunction

endpackage

// ----- design/jpeg_sof0_dimension_sniffer_core.sv -----
// A result beat passes the parser's byte register, then the result buffer, before it is offered.
// Throughput: one byte beat per cycle while byte_stall is low.
// The two-entry result buffer sets the stall: byte beats hold off only while
// it is full, or holds one result with a byte still being parsed.
// Reset clears the parser to wait for a start-of-file byte and empties the buffer.
// ----------------------------------------------------------------------------
// jpeg_sof0_dimension_sniffer_core: JPEG SOF0 width / height extractor
// Checks the SOI / APP0 / JFIF header, skips segments by length and reports
// the SOF0 dimensions or an error status, at most once per file.
// ----------------------------------------------------------------------------
module jpeg_sof0_dimension_sniffer_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  jsds_pkg::byte_beat_t   byte_beat,
  output logic                   result_valid,
  input  logic                   result_stall,
  output jsds_pkg::result_beat_t result_beat
);
  import jsds_pkg::*;

  logic         pend_valid;
  logic         res_valid;
  result_beat_t res;
  logic [1:0]   count;

  // hold bytes whenever a result could find no room
  assign byte_stall = (count == 2'd2) || (count == 2'd1 && pend_valid);

  jsds_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (byte_valid && !byte_stall),
    .beat       (byte_beat),
    .pend_valid (pend_valid),
    .res_valid  (res_valid),
    .res        (res)
  );

  jsds_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (res_valid),
    .push_beat    (res),
    .count        (count),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

endmodule

// ----- design/jsds_parse.sv -----
// ----------------------------------------------------------------------------
// jsds_parse: byte register and segment walker
// Registers each accepted byte beat, then advances the header / segment
// parser by one byte and emits at most one result beat for the file.
// ----------------------------------------------------------------------------
module jsds_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  beat_valid,
  input  jsds_pkg::byte_beat_t  beat,
  output logic                  pend_valid,
  output logic                  res_valid,
  output jsds_pkg::result_beat_t res
);
  import jsds_pkg::*;

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_HEAD = 3'd1;
  localparam logic [2:0] PH_SKIP = 3'd2;
  localparam logic [2:0] PH_SEG  = 3'd3;
  localparam logic [2:0] PH_SOF  = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  byte_beat_t  pend;

  logic [2:0]  phase, phase_next;
  logic [3:0]  header_offset, header_offset_next;
  logic [15:0] skip_count, skip_count_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] height_acc, height_acc_next;
  logic [7:0]  width_high, width_high_next;

  logic [2:0]  ph;
  logic [3:0]  o;
  logic [15:0] sk, sk_dec, app_rest, seg_len, seg_rest;
  logic [7:0]  lh, b;
  logic [15:0] ha;
  logic [7:0]  wh;
  logic        give;
  result_beat_t give_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= beat_valid;
    end
    if (beat_valid) begin
      pend <= beat;
    end
  end

  always_comb begin
    b        = pend.data_byte;
    ph       = pend.start_of_file ? PH_HEAD : phase;
    o        = pend.start_of_file ? 4'd0 : header_offset;
    sk       = pend.start_of_file ? 16'd0 : skip_count;
    lh       = pend.start_of_file ? 8'd0 : length_high;
    ha       = pend.start_of_file ? 16'd0 : height_acc;
    wh       = pend.start_of_file ? 8'd0 : width_high;
    sk_dec   = (sk != 16'd0) ? sk - 16'd1 : sk;
    app_rest = sk - APP0_MIN_LEN;
    seg_len  = {lh, b};
    seg_rest = seg_len - SEG_MIN_LEN;

    phase_next         = ph;
    header_offset_next = o;
    skip_count_next    = sk;
    length_high_next   = lh;
    height_acc_next    = ha;
    width_high_next    = wh;
    give               = 1'b0;
    give_beat          = '{image_width: 16'd0, image_height: 16'd0, status: STATUS_FOUND};

    unique case (ph)
      PH_HEAD: begin
        header_offset_next = o + 4'd1;
        if (o < HDR_LEN_HIGH) begin
          if (b != head_expect(o)) begin
            give             = 1'b1;
            give_beat.status = STATUS_BAD_SOI;
          end
        end else if (o == HDR_LEN_HIGH) begin
          length_high_next = b;
        end else if (o == HDR_LEN_LOW) begin
          skip_count_next = {lh, b};
        end else if (o <= HDR_TAG_LAST) begin
          if (b != head_expect(o)) begin
            give             = 1'b1;
            give_beat.status = STATUS_NOT_JFIF;
          end else if (o == HDR_TAG_LAST) begin
            if (sk < APP0_MIN_LEN) begin
              give             = 1'b1;
              give_beat.status = STATUS_BAD_LEN;
            end else begin
              skip_count_next    = app_rest;
              header_offset_next = 4'd0;
              phase_next         = (app_rest == 16'd0) ? PH_SEG : PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        skip_count_next = sk_dec;
        if (sk_dec == 16'd0) begin
          header_offset_next = 4'd0;
          phase_next         = PH_SEG;
        end
      end
      PH_SEG: begin
        priority if (o == 4'd0) begin
          if (b != MARKER_PREFIX) begin
            give             = 1'b1;
            give_beat.status = STATUS_NO_FF;
          end else begin
            header_offset_next = 4'd1;
          end
        end else if (o == 4'd1) begin
          header_offset_next = 4'd2;
          if (b == MARKER_SOF0) begin
            phase_next = PH_SOF;
          end
        end else if (o == 4'd2) begin
          length_high_next   = b;
          header_offset_next = 4'd3;
        end else begin
          skip_count_next = seg_len;
          if (seg_len < SEG_MIN_LEN) begin
            give             = 1'b1;
            give_beat.status = STATUS_BAD_LEN;
          end else begin
            skip_count_next    = seg_rest;
            header_offset_next = 4'd0;
            phase_next         = (seg_rest == 16'd0) ? PH_SEG : PH_SKIP;
          end
        end
      end
      PH_SOF: begin
        header_offset_next = o + 4'd1;
        if (o == 4'd5) begin
          height_acc_next = {b, 8'h00};
        end else if (o == 4'd6) begin
          height_acc_next = ha | {8'h00, b};
        end else if (o == 4'd7) begin
          width_high_next = b;
        end else if (o >= 4'd8) begin
          give                   = 1'b1;
          give_beat.image_width  = {wh, b};
          give_beat.image_height = ha;
          give_beat.status       = STATUS_FOUND;
        end
      end
      default: begin
      end
    endcase

    if (give) begin
      phase_next = PH_DONE;
    end else if (pend.end_of_file && phase_next != PH_WAIT && phase_next != PH_DONE) begin
      // file ran out before any result
      give       = 1'b1;
      give_beat  = '{image_width: 16'd0, image_height: 16'd0, status: STATUS_EARLY};
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      header_offset <= 4'd0;
      skip_count    <= 16'd0;
      length_high   <= 8'd0;
      height_acc    <= 16'd0;
      width_high    <= 8'd0;
    end else if (pend_valid) begin
      phase         <= phase_next;
      header_offset <= header_offset_next;
      skip_count    <= skip_count_next;
      length_high   <= length_high_next;
      height_acc    <= height_acc_next;
      width_high    <= width_high_next;
    end
  end

  assign res_valid = pend_valid && give;
  assign res       = give_beat;

endmodule

// ----- design/jsds_out_fifo.sv -----
// ----------------------------------------------------------------------------
// jsds_out_fifo: two-entry result buffer
// Holds result beats so the byte side can keep flowing while the result side
// stalls, until the buffer has no room for another result.
// ----------------------------------------------------------------------------
module jsds_out_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  jsds_pkg::result_beat_t push_beat,
  output logic [1:0]             count,
  output logic                   result_valid,
  input  logic                   result_stall,
  output jsds_pkg::result_beat_t result_beat
);
  import jsds_pkg::*;

  result_beat_t mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic         pop;

  assign result_valid = (count != 2'd0);
  assign pop          = result_valid && !result_stall;
  assign result_beat  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      mem[wr_ptr] <= push_beat;
    end
  end

endmodule

// ----- tb/sof0_board_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sof0_board_pkg: size-report scoreboard for the JPEG SOF0 dimension sniffer
// Tracks the parser state byte by byte, queues the report each file should
// raise, and compares the reports that come out of the block in order.
// ----------------------------------------------------------------------------
package sof0_board_pkg;
  import jsds_pkg::*;

  localparam logic [7:0] SOI_MARKER  = 8'hD8;
  localparam logic [7:0] APP0_MARKER = 8'hE0;

  // FF D8 FF E0, two length bytes, then the "JFIF\0" tag
  localparam logic [7:0] FILE_HEADER [0:10] = '{
    MARKER_PREFIX, SOI_MARKER, MARKER_PREFIX, APP0_MARKER, 8'h00, 8'h00,
    8'h4A, 8'h46, 8'h49, 8'h46, 8'h00
  };

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_HEADER, SCAN_SKIP, SCAN_SEGMENT, SCAN_SOF, SCAN_DONE
  } scan_phase_e;

  class sof0_size_board;
    scan_phase_e  scan;
    logic [3:0]   pos;
    logic [15:0]  skip_left;
    logic [7:0]   len_hi;
    logic [15:0]  height_word;
    logic [7:0]   width_hi;
    bit           answered;
    result_beat_t awaited[$];
    int           mismatches;
    int           reports_checked;
    int           bytes_noted;
    int           status_tally[8];

    function new();
      clear();
      scan = SCAN_IDLE;
      mismatches = 0;
      reports_checked = 0;
      bytes_noted = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function void clear();
      scan = SCAN_IDLE;
      pos = '0;
      skip_left = '0;
      len_hi = '0;
      height_word = '0;
      width_hi = '0;
      answered = 1'b0;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void emit(logic [15:0] w, logic [15:0] h, logic [2:0] st);
      result_beat_t r;
      r.image_width = w;
      r.image_height = h;
      r.status = st;
      awaited.push_back(r);
      scan = SCAN_DONE;
      answered = 1'b1;
    endfunction

    function void enter_segment();
      pos = '0;
      scan = (skip_left == 0) ? SCAN_SEGMENT : SCAN_SKIP;
    endfunction

    // Advance the parser by one accepted byte beat
    function void note_byte(byte_beat_t b);
      logic [7:0] d;
      logic [3:0] o;
      bit         gave;
      d = b.data_byte;
      gave = 1'b0;
      bytes_noted++;
      if (b.start_of_file) begin
        clear();
        scan = SCAN_HEADER;
      end
      o = pos;
      case (scan)
        SCAN_HEADER: begin
          if (o < HDR_LEN_HIGH) begin
            if (d != FILE_HEADER[o]) begin
              emit('0, '0, STATUS_BAD_SOI);
              gave = 1'b1;
            end
          end else if (o == HDR_LEN_HIGH) begin
            len_hi = d;
          end else if (o == HDR_LEN_LOW) begin
            skip_left = {len_hi, d};
          end else if (d != FILE_HEADER[o]) begin
            emit('0, '0, STATUS_NOT_JFIF);
            gave = 1'b1;
          end else if (o == HDR_TAG_LAST) begin
            if (skip_left < APP0_MIN_LEN) begin
              emit('0, '0, STATUS_BAD_LEN);
              gave = 1'b1;
            end else begin
              skip_left = skip_left - APP0_MIN_LEN;
              enter_segment();
            end
          end
          if (scan == SCAN_HEADER) pos = o + 4'd1;
        end
        SCAN_SKIP: begin
          if (skip_left != 0) skip_left = skip_left - 16'd1;
          if (skip_left == 0) begin
            pos = '0;
            scan = SCAN_SEGMENT;
          end
        end
        SCAN_SEGMENT: begin
          case (o)
            4'd0: begin
              if (d != MARKER_PREFIX) begin
                emit('0, '0, STATUS_NO_FF);
                gave = 1'b1;
              end else begin
                pos = 4'd1;
              end
            end
            4'd1: begin
              pos = 4'd2;
              if (d == MARKER_SOF0) scan = SCAN_SOF;
            end
            4'd2: begin
              len_hi = d;
              pos = 4'd3;
            end
            default: begin
              skip_left = {len_hi, d};
              if (skip_left < SEG_MIN_LEN) begin
                emit('0, '0, STATUS_BAD_LEN);
                gave = 1'b1;
              end else begin
                skip_left = skip_left - SEG_MIN_LEN;
                enter_segment();
              end
            end
          endcase
        end
        SCAN_SOF: begin
          // length and precision bytes pass by unread
          if (o >= 4'd8) begin
            emit({width_hi, d}, height_word, STATUS_FOUND);
            gave = 1'b1;
          end else begin
            if (o == 4'd5) height_word = {d, 8'h00};
            else if (o == 4'd6) height_word = height_word | {8'h00, d};
            else if (o == 4'd7) width_hi = d;
            pos = o + 4'd1;
          end
        end
        default: ;
      endcase
      if (b.end_of_file && !gave && !answered && scan != SCAN_IDLE && scan != SCAN_DONE)
        emit('0, '0, STATUS_EARLY);
    endfunction

    // Compare one accepted result beat with the oldest awaited report
    function void check_report(result_beat_t got);
      result_beat_t want;
      reports_checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: report with none awaited: width %0d height %0d status %0d",
                   got.image_width, got.image_height, got.status);
        return;
      end
      want = awaited.pop_front();
      status_tally[want.status]++;
      if (got.image_width !== want.image_width || got.image_height !== want.image_height ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: report %0d: expected w %0d h %0d st %0d, got w %0d h %0d st %0d",
                   reports_checked, want.image_width, want.image_height, want.status,
                   got.image_width, got.image_height, got.status);
      end
    endfunction
  endclass

endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: byte-stream test for jpeg_sof0_dimension_sniffer_core
// Feeds whole JPEG headers (clean, truncated, corrupted, short lengths,
// abandoned mid-file) with random gaps and result back-pressure, and checks
// every size report against a byte-accurate parser model.
// ----------------------------------------------------------------------------
module testbench;
  import jsds_pkg::*;
  import sof0_board_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int BYTE_TARGET   = 1250;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {
    FILE_CLEAN, FILE_TRUNCATED, FILE_CORRUPTED, FILE_SHORT_APP0,
    FILE_SHORT_SEGMENT, FILE_ABANDONED, FILE_LONE_BYTE
  } file_flavour_e;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         byte_valid = 1'b0;
  logic         byte_stall;
  byte_beat_t   byte_beat = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_beat_t result_beat;

  sof0_size_board board;
  byte_beat_t     file_bytes[$];
  int             hold_request = 0;
  int             files_sent = 0;
  int             cycle_count = 0;

  jpeg_sof0_dimension_sniffer_core dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_beat    (byte_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("ERROR: timed out after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_report(result_beat);
  end

  // Result side: stall after each beat for a drawn count, in runs that are
  // either quiet or busy; a long hold-off overrides the draw
  initial begin : result_pacing
    int pause;
    int run_left;
    bit steady;
    pause = 0;
    run_left = 0;
    steady = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        pause = hold_request;
        hold_request = 0;
      end else if (!rst && result_valid && !result_stall) begin
        if (run_left == 0) begin
          steady = ($urandom_range(0, 2) == 0);
          run_left = $urandom_range(5, 20);
        end
        run_left--;
        pause = steady ? 0 : $urandom_range(0, 10);
      end
      if (pause != 0) begin
        result_stall <= 1'b1;
        pause--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  function automatic byte_beat_t beat_of(logic [7:0] d, bit s, bit e);
    byte_beat_t b;
    b.data_byte = d;
    b.start_of_file = s;
    b.end_of_file = e;
    return b;
  endfunction

  function automatic logic [15:0] draw_dimension();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void push_header(ref logic [7:0] raw[$], input int app_len);
    for (int k = 0; k < 11; k++)
      raw.push_back(k == 4 ? 8'(app_len >> 8) : k == 5 ? 8'(app_len) : FILE_HEADER[k]);
  endfunction

  // FF C0, length 17, precision 8, then height and width big-endian
  function automatic void push_sof(ref logic [7:0] raw[$], input logic [15:0] h,
                                   input logic [15:0] w);
    raw.push_back(MARKER_PREFIX);
    raw.push_back(MARKER_SOF0);
    raw.push_back(8'h00);
    raw.push_back(8'h11);
    raw.push_back(8'h08);
    raw.push_back(h[15:8]);
    raw.push_back(h[7:0]);
    raw.push_back(w[15:8]);
    raw.push_back(w[7:0]);
  endfunction

  function automatic void frame_bytes(input logic [7:0] raw[$], input bit with_end);
    foreach (raw[i])
      file_bytes.push_back(beat_of(raw[i], i == 0, with_end && i == raw.size() - 1));
  endfunction

  function automatic void compose_file();
    file_flavour_e flavour;
    logic [7:0]    raw[$];
    logic [7:0]    marker;
    int            pick, app_len, seg_count, seg_len, cut, idx;
    pick = $urandom_range(0, 19);
    flavour = pick < 9  ? FILE_CLEAN :
              pick < 11 ? FILE_TRUNCATED :
              pick < 13 ? FILE_CORRUPTED :
              pick < 15 ? FILE_SHORT_APP0 :
              pick < 17 ? FILE_SHORT_SEGMENT :
              pick < 19 ? FILE_ABANDONED : FILE_LONE_BYTE;
    file_bytes = {};
    // stray bytes between files, parsed or ignored depending on what came before
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3))
        file_bytes.push_back(beat_of(8'($urandom_range(0, 255)), 1'b0,
                                     1'($urandom_range(0, 1))));
    if (flavour == FILE_LONE_BYTE) begin
      raw.push_back(8'($urandom_range(0, 255)));
    end else begin
      app_len = (flavour == FILE_SHORT_APP0) ? $urandom_range(0, 6) : $urandom_range(7, 14);
      push_header(raw, app_len);
      for (int k = 7; k < app_len; k++) raw.push_back(8'($urandom_range(0, 255)));
      seg_count = (flavour == FILE_SHORT_SEGMENT) ? $urandom_range(1, 3) : $urandom_range(0, 3);
      for (int s = 0; s < seg_count; s++) begin
        marker = 8'($urandom_range(0, 255));
        if (marker == MARKER_SOF0) marker = marker + 8'd1;
        raw.push_back(MARKER_PREFIX);
        raw.push_back(marker);
        seg_len = (flavour == FILE_SHORT_SEGMENT && s == seg_count - 1) ?
                  $urandom_range(0, 1) : $urandom_range(2, 9);
        raw.push_back(8'(seg_len >> 8));
        raw.push_back(8'(seg_len));
        for (int k = 2; k < seg_len; k++) raw.push_back(8'($urandom_range(0, 255)));
      end
      push_sof(raw, draw_dimension(), draw_dimension());
      repeat ($urandom_range(0, 4)) raw.push_back(8'($urandom_range(0, 255)));
      if (flavour == FILE_CORRUPTED) begin
        idx = $urandom_range(0, raw.size() - 1);
        raw[idx] = raw[idx] ^ 8'($urandom_range(1, 255));
      end
      if (flavour == FILE_TRUNCATED || flavour == FILE_ABANDONED) begin
        cut = $urandom_range(1, raw.size() - 1);
        raw = raw[0:cut-1];
      end
    end
    frame_bytes(raw, flavour != FILE_ABANDONED);
  endfunction

  task automatic offer_byte(input byte_beat_t beat, input bit steady);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_beat  <= beat;
    do @(posedge clk); while (byte_stall);
    board.note_byte(beat);
  endtask

  task automatic send_file(input bit steady);
    foreach (file_bytes[i]) offer_byte(file_bytes[i], steady);
    files_sent++;
  endtask

  // Drop valid and hold until every awaited report is in
  task automatic drain();
    byte_valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  initial begin : stimulus
    logic [7:0] raw[$];
    bit         mid_drained;
    board = new();
    mid_drained = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bytes before any start, end flag included, are ignored
    offer_byte(beat_of(8'h00, 1'b0, 1'b0), 1'b0);
    offer_byte(beat_of(8'hFF, 1'b0, 1'b1), 1'b0);
    // start and end on one good byte: early end
    offer_byte(beat_of(MARKER_PREFIX, 1'b1, 1'b1), 1'b0);
    // bad first byte
    offer_byte(beat_of(8'h00, 1'b1, 1'b0), 1'b0);
    // shortest legal file, zero height and full-scale width
    push_header(raw, 7);
    push_sof(raw, 16'h0000, 16'hFFFF);
    file_bytes = {};
    frame_bytes(raw, 1'b1);
    send_file(1'b0);

    // block the result side and keep reports coming so the input backs up
    hold_request = LONG_HOLD;
    repeat (8) begin
      file_bytes = {};
      file_bytes.push_back(beat_of(8'h00, 1'b1, 1'b0));
      send_file(1'b1);
    end
    drain();

    while (board.bytes_noted < BYTE_TARGET) begin
      compose_file();
      send_file($urandom_range(0, 3) == 0);
      if (!mid_drained && board.bytes_noted >= BYTE_TARGET / 2) begin
        mid_drained = 1'b1;
        drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d bytes in %0d files and %0d reports in %0d cycles.",
             board.bytes_noted, files_sent, board.reports_checked, cycle_count);
    $display("Reports: %0d sizes, %0d header/marker faults, %0d early ends, %0d bad lengths.",
             board.status_tally[STATUS_FOUND],
             board.status_tally[STATUS_BAD_SOI] + board.status_tally[STATUS_NOT_JFIF] +
             board.status_tally[STATUS_NO_FF],
             board.status_tally[STATUS_EARLY], board.status_tally[STATUS_BAD_LEN]);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("ERROR: %0d mismatches, %0d reports never seen",
               board.mismatches, board.outstanding());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
